[hdl/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types, sizes and codes of the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;

    // counter wide enough to hold CAPACITY itself
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // width used when comparing a cell position with the requested index
    localparam int POS_W = (CNT_W > 6) ? CNT_W : 6;

    // reduction tree group size
    localparam int GRP = 8;
    localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_GET    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_GETKEY = 2'd3;

    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_CMP    = 3'd1;
    localparam logic [2:0] OP_WRVAL  = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_SHIFT  = 3'd4;

    typedef logic [VALUE_BITS-1:0] t_val;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
        logic [31:0] value;
        logic [5:0]  index;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [63:0] key_out;
        logic        status;
        logic [6:0]  count;
    } t_out;

    // command broadcast to every cell
    typedef struct packed {
        logic [2:0] op;
        logic       by_idx;
    } t_cell_cmd;

    function automatic t_val fit_val(input logic [31:0] v);
        logic [95:0] wide;
        wide = {64'd0, v};
        return wide[VALUE_BITS-1:0];
    endfunction

endpackage

[hdl/sorted_key_value_table.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Sorted key/value table built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each operation runs through the accept step, in which every cell compares
// its key against the request, the registered OR tree that finds the matching
// cell (states S_RED1 and S_RED2), and the apply step, in which the cells
// apply the update (value write, insert with shift up, or remove with shift
// down) and the result word is loaded. The input is taken again once the
// table is back in idle, so a new word is not accepted while one is in flight;
// a result that is not taken holds the apply step until the output register
// frees up.
module sorted_key_value_table import skvt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RED1  = 2'd1;
    localparam logic [1:0] S_RED2  = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    t_in              r_item;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;

    t_in              w_req;
    t_cell_cmd        w_cmd;
    logic             w_go;
    logic             w_full;
    logic             w_hit;
    logic [63:0]      w_data;
    logic [POS_W-1:0] w_req_idx;
    t_val             w_val;

    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_sel;
    logic [63:0]         w_key [CAPACITY];
    t_val                w_cval [CAPACITY];
    logic [63:0]         w_rd [CAPACITY];

    assign w_req     = (r_state == S_IDLE) ? i_in : r_item;
    assign w_req_idx = POS_W'(w_req.index);
    assign w_val     = fit_val(w_req.value);
    assign w_full    = r_count == CNT_W'(CAPACITY);
    assign w_go      = !r_out_valid || i_out_ready;

    always_comb begin
        w_cmd.by_idx = w_req.action == ACT_GETKEY;
        w_cmd.op     = OP_HOLD;
        n_state      = r_state;
        n_count      = r_count;
        n_out        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.op = OP_CMP;
                    n_state  = S_RED1;
                end
            end
            S_RED1: n_state = S_RED2;
            S_RED2: n_state = S_APPLY;
            S_APPLY: begin
                n_out.found = w_hit;
                case (r_item.action)
                    ACT_SET: begin
                        if (w_hit) begin
                            w_cmd.op = OP_WRVAL;
                        end else if (w_full) begin
                            n_out.status = 1'b1;
                        end else begin
                            w_cmd.op = OP_INSERT;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end
                    ACT_GET: begin
                        if (w_hit) begin
                            n_out.value_out = w_data[31:0];
                        end
                    end
                    ACT_REMOVE: begin
                        if (w_hit) begin
                            w_cmd.op = OP_SHIFT;
                            n_count  = r_count - CNT_W'(1);
                        end
                    end
                    default: begin
                        if (w_hit) begin
                            n_out.key_out = w_data;
                        end
                    end
                endcase
                n_out.count = 7'(n_count);
                if (!w_go) begin
                    w_cmd.op = OP_HOLD;
                    n_count  = r_count;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_APPLY && w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in;
        end
        if (r_state == S_APPLY && w_go) begin
            r_out <= n_out;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic        w_left_lt;
        logic [63:0] w_left_key;
        t_val        w_left_val;
        logic [63:0] w_right_key;
        t_val        w_right_val;

        if (g == 0) begin : g_first
            // virtual entry below every key
            assign w_left_lt  = 1'b1;
            assign w_left_key = '0;
            assign w_left_val = '0;
        end else begin : g_mid
            assign w_left_lt  = w_lt[g-1];
            assign w_left_key = w_key[g-1];
            assign w_left_val = w_cval[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_key = '0;
            assign w_right_val = '0;
        end else begin : g_inner
            assign w_right_key = w_key[g+1];
            assign w_right_val = w_cval[g+1];
        end

        skvt_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_pos       (POS_W'(g)),
            .i_count     (r_count),
            .i_req_idx   (w_req_idx),
            .i_key       (w_req.key),
            .i_val       (w_val),
            .i_left_lt   (w_left_lt),
            .i_left_key  (w_left_key),
            .i_left_val  (w_left_val),
            .i_right_key (w_right_key),
            .i_right_val (w_right_val),
            .o_lt        (w_lt[g]),
            .o_sel       (w_sel[g]),
            .o_key       (w_key[g]),
            .o_val       (w_cval[g]),
            .o_rd        (w_rd[g])
        );
    end

    skvt_tree u_tree (
        .i_clk  (i_clk),
        .i_sel  (w_sel),
        .i_data (w_rd),
        .o_any  (w_hit),
        .o_data (w_data)
    );

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[hdl/skvt_cell.sv]
// ----------------------------------------------------------------------------
// skvt_cell
// One table slot: holds a key/value pair, compares against the broadcast key or
// requested index and moves data to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module skvt_cell import skvt_pkg::*; (
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic [POS_W-1:0] i_pos,
    input  logic [CNT_W-1:0] i_count,
    input  logic [POS_W-1:0] i_req_idx,
    input  logic [63:0]      i_key,
    input  t_val             i_val,
    input  logic             i_left_lt,
    input  logic [63:0]      i_left_key,
    input  t_val             i_left_val,
    input  logic [63:0]      i_right_key,
    input  t_val             i_right_val,
    output logic             o_lt,
    output logic             o_sel,
    output logic [63:0]      o_key,
    output t_val             o_val,
    output logic [63:0]      o_rd
);

    logic [63:0] r_key;
    t_val        r_val;
    logic        r_lt;
    logic        r_sel;
    logic        w_valid;

    assign w_valid = i_pos < POS_W'(i_count);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CMP: begin
                r_lt  <= w_valid && (r_key < i_key);
                r_sel <= w_valid && (i_cmd.by_idx ? (i_pos == i_req_idx) : (r_key == i_key));
            end
            OP_WRVAL: begin
                if (r_sel) begin
                    r_val <= i_val;
                end
            end
            OP_INSERT: begin
                // first slot not below the key takes the new word, the rest move up
                if (!r_lt) begin
                    if (i_left_lt) begin
                        r_key <= i_key;
                        r_val <= i_val;
                    end else begin
                        r_key <= i_left_key;
                        r_val <= i_left_val;
                    end
                end
            end
            OP_SHIFT: begin
                if (!r_lt) begin
                    r_key <= i_right_key;
                    r_val <= i_right_val;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_lt  = r_lt;
    assign o_sel = r_sel;
    assign o_key = r_key;
    assign o_val = r_val;
    assign o_rd  = i_cmd.by_idx ? r_key : 64'(r_val);

endmodule

[hdl/skvt_tree.sv]
// ----------------------------------------------------------------------------
// skvt_tree
// Two-level registered OR tree that collects the selected cell's word.
// ----------------------------------------------------------------------------
module skvt_tree import skvt_pkg::*; (
    input  logic                i_clk,
    input  logic [CAPACITY-1:0] i_sel,
    input  logic [63:0]         i_data [CAPACITY],
    output logic                o_any,
    output logic [63:0]         o_data
);

    logic        n_grp_any [NGRP];
    logic [63:0] n_grp_dat [NGRP];
    logic        r_grp_any [NGRP];
    logic [63:0] r_grp_dat [NGRP];
    logic        n_any;
    logic [63:0] n_dat;
    logic        r_any;
    logic [63:0] r_dat;

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_any[g] = 1'b0;
            n_grp_dat[g] = '0;
            for (int m = 0; m < GRP; m++) begin
                if (g * GRP + m < CAPACITY) begin
                    if (i_sel[g * GRP + m]) begin
                        n_grp_any[g] = 1'b1;
                        n_grp_dat[g] = n_grp_dat[g] | i_data[g * GRP + m];
                    end
                end
            end
        end
    end

    always_comb begin
        n_any = 1'b0;
        n_dat = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_any = n_any | r_grp_any[g];
            n_dat = n_dat | r_grp_dat[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= n_grp_any;
        r_grp_dat <= n_grp_dat;
        r_any     <= n_any;
        r_dat     <= n_dat;
    end

    assign o_any  = r_any;
    assign o_data = r_dat;

endmodule
